### rtl/ptt_pkg.sv
// shared constants for the pressure trend tracker
package ptt_pkg;

    // field widths
    localparam int PRES_W  = 17;
    localparam int TIME_W  = 48;
    localparam int WIN_W   = 7;
    localparam int SCALE_W = 17;
    localparam int LIM_W   = 18;
    localparam int ULIM_W  = 17;
    localparam int RATE_W  = 21;
    localparam int CLS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // serial divider sizes: quotient never exceeds 21 bits
    localparam int QUOT_W = 21;
    localparam int DVD_W  = 49;
    localparam int DVS_W  = 48;

    localparam logic [31:0]        US_PER_HOUR = 32'd3600000000;
    localparam logic signed [48:0] MIN_SPAN_US = 49'sd360000000;
    localparam logic [31:0]        SCALE_ONE   = 32'd65536;

    // class codes
    localparam logic [CLS_W-1:0] CLS_FALL_FAST = 3'd0;
    localparam logic [CLS_W-1:0] CLS_FALL      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_STEADY    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_RISE      = 3'd3;
    localparam logic [CLS_W-1:0] CLS_RISE_FAST = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_FAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd7;

    // register reset values
    localparam logic [WIN_W-1:0]          RST_SHORT_WINDOW = 7'd4;
    localparam logic [WIN_W-1:0]          RST_LONG_WINDOW  = 7'd12;
    localparam logic [SCALE_W-1:0]        RST_SHORT_SCALE  = 17'd21845;
    localparam logic signed [LIM_W-1:0]   RST_FALL_FAST    = -18'sd250;
    localparam logic signed [LIM_W-1:0]   RST_FALL         = -18'sd50;
    localparam logic [ULIM_W-1:0]         RST_STEADY       = 17'd50;
    localparam logic [ULIM_W-1:0]         RST_RISE         = 17'd250;
    localparam logic [TIME_W-1:0]         RST_MIN_INTERVAL = 48'd900000000;

    // rate saturation bounds
    localparam logic [RATE_W-1:0] RATE_POS_MAX = 21'h0FFFFF;
    localparam logic [RATE_W-1:0] RATE_NEG_MIN = 21'h100000;
    localparam logic [QUOT_W:0]   RATE_NEG_MAG = 22'd1048576;

endpackage

### rtl/ptt_div.sv
// restoring serial divider, one quotient bit per cycle
module ptt_div
    import ptt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DVS_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [DVS_W:0] w_shift;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    // quotient fits QUOT_W bits, so the top part of the dividend starts as the remainder
    assign w_shift = {r_rem, r_quo[QUOT_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(QUOT_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend[DVD_W-1:QUOT_W]);
            r_quo <= i_dividend[QUOT_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/pressure_trend_tracker.sv
// pressure trend tracker top level: history ring, sequencer, shared multiplier
// For each valid window a transaction runs a fixed sequence of ring read, four limit
// products on the shared 19x33 multiplier, the rate product and a 21-step serial
// division (one quotient bit a cycle); a window out of reach skips it. The input
// stalls for the whole run.
// A finished result waits in the output register while the next transaction is
// taken; it only holds the sequencer at its last step if still not taken then.
// The history ring is a memory of HISTORY_DEPTH entries with one write port and one
// registered read port; it needs no clearing pass after reset.
module pressure_trend_tracker
    import ptt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 96
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [PRES_W-1:0]           i_pressure_pa,
    input  logic [TIME_W-1:0]           i_sample_time_us,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_short_valid,
    output logic signed [RATE_W-1:0]    o_short_rate,
    output logic [CLS_W-1:0]            o_short_class,
    output logic                        o_long_valid,
    output logic signed [RATE_W-1:0]    o_long_rate,
    output logic [CLS_W-1:0]            o_long_class,
    output logic                        o_sample_stored,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = (IW + 1 > WIN_W) ? IW + 1 : WIN_W;
    localparam int MW = PRES_W + TIME_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADDR     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_CHK      = 4'd3;
    localparam logic [3:0] S_LIM      = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_DIV_GO   = 4'd6;
    localparam logic [3:0] S_DIV_WAIT = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;
    localparam logic [3:0] S_STORE    = 4'd9;

    // control state
    logic [3:0]    r_state,      n_state;
    logic          r_win_long,   n_win_long;
    logic [2:0]    r_lim_cnt,    n_lim_cnt;
    logic [IW-1:0] r_next_slot,  n_next_slot;
    logic [FW-1:0] r_fill,       n_fill;
    logic [TIME_W-1:0] r_last_time, n_last_time;
    logic          r_out_valid,  n_out_valid;

    // configuration
    logic [WIN_W-1:0]          r_short_window, n_short_window;
    logic [WIN_W-1:0]          r_long_window,  n_long_window;
    logic [SCALE_W-1:0]        r_short_scale,  n_short_scale;
    logic signed [LIM_W-1:0]   r_fall_fast,    n_fall_fast;
    logic signed [LIM_W-1:0]   r_fall,         n_fall;
    logic [ULIM_W-1:0]         r_steady,       n_steady;
    logic [ULIM_W-1:0]         r_rise,         n_rise;
    logic [TIME_W-1:0]         r_min_int,      n_min_int;

    // payload
    logic [PRES_W-1:0]         r_in_p,    n_in_p;
    logic [TIME_W-1:0]         r_in_t,    n_in_t;
    logic [PRES_W-1:0]         r_new_p,   n_new_p;
    logic signed [LIM_W-1:0]   r_delta,   n_delta;
    logic signed [DVD_W-1:0]   r_span,    n_span;
    logic [3:0]                r_flags,   n_flags;
    logic signed [51:0]        r_prod;
    logic                      r_res_sv,  n_res_sv;
    logic signed [RATE_W-1:0]  r_res_sr,  n_res_sr;
    logic [CLS_W-1:0]          r_res_sc,  n_res_sc;
    logic                      r_res_lv,  n_res_lv;
    logic signed [RATE_W-1:0]  r_res_lr,  n_res_lr;
    logic [CLS_W-1:0]          r_res_lc,  n_res_lc;
    logic                      r_out_sv,  n_out_sv;
    logic signed [RATE_W-1:0]  r_out_sr,  n_out_sr;
    logic [CLS_W-1:0]          r_out_sc,  n_out_sc;
    logic                      r_out_lv,  n_out_lv;
    logic signed [RATE_W-1:0]  r_out_lr,  n_out_lr;
    logic [CLS_W-1:0]          r_out_lc,  n_out_lc;
    logic                      r_out_st,  n_out_st;

    // history ring
    logic [MW-1:0] r_ring [HISTORY_DEPTH];
    logic [MW-1:0] r_ring_q;

    logic [WIN_W-1:0]        w_window;
    logic [CW-1:0]           w_win_c;
    logic [CW-1:0]           w_fill_c;
    logic [CW-1:0]           w_depth_c;
    logic                    w_win_ok;
    logic [IW-1:0]           w_newest;
    logic [CW-1:0]           w_old_sum;
    logic [CW-1:0]           w_old_c;
    logic [IW-1:0]           w_rd_addr;
    logic [LIM_W-1:0]        w_mag;
    logic signed [18:0]      w_mul_a;
    logic [31:0]             w_mul_b;
    logic signed [51:0]      w_ds;
    logic [1:0]              w_lim_idx;
    logic                    w_lim_hit;
    logic [CLS_W-1:0]        w_class;
    logic [QUOT_W:0]         w_quot_x;
    logic signed [RATE_W-1:0] w_rate;
    logic signed [DVD_W-1:0] w_gap;
    logic                    w_do_store;
    logic                    w_out_free;
    logic                    w_ring_we;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [QUOT_W-1:0]       w_quot;

    ptt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod[DVD_W-1:0]),
        .i_divisor  (r_span[DVS_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // window bookkeeping
    assign w_window  = r_win_long ? r_long_window : r_short_window;
    assign w_win_c   = CW'(w_window);
    assign w_fill_c  = CW'(r_fill);
    assign w_depth_c = CW'(HISTORY_DEPTH);
    assign w_win_ok  = (w_win_c < w_depth_c) && (w_fill_c > w_win_c);
    assign w_newest  = (r_next_slot == '0) ? IW'(HISTORY_DEPTH - 1) : r_next_slot - 1'b1;
    assign w_old_sum = CW'(w_newest) + w_depth_c - w_win_c;
    assign w_old_c   = (w_old_sum >= w_depth_c) ? w_old_sum - w_depth_c : w_old_sum;
    assign w_rd_addr = w_old_c[IW-1:0];

    // shared multiplier operands: scaled limits during the limit sweep, else rate product
    assign w_mag = r_delta[LIM_W-1] ? LIM_W'(-r_delta) : r_delta;

    always_comb begin
        w_mul_a = $signed({1'b0, w_mag});
        w_mul_b = US_PER_HOUR;
        if (r_state == S_LIM) begin
            w_mul_b = r_win_long ? SCALE_ONE : 32'(r_short_scale);
            case (r_lim_cnt[1:0])
                2'd0:    w_mul_a = 19'(r_fall_fast);
                2'd1:    w_mul_a = 19'(r_fall);
                2'd2:    w_mul_a = $signed({2'b00, r_steady});
                default: w_mul_a = $signed({2'b00, r_rise});
            endcase
        end
    end

    assign w_ds      = {{18{r_delta[LIM_W-1]}}, r_delta, 16'b0};
    assign w_lim_idx = 2'(r_lim_cnt - 3'd1);
    // falling limits are strict, steady and rise limits inclusive
    assign w_lim_hit = w_lim_idx[1] ? (w_ds <= r_prod) : (w_ds < r_prod);

    always_comb begin
        if (r_flags[0])      w_class = CLS_FALL_FAST;
        else if (r_flags[1]) w_class = CLS_FALL;
        else if (r_flags[2]) w_class = CLS_STEADY;
        else if (r_flags[3]) w_class = CLS_RISE;
        else                 w_class = CLS_RISE_FAST;
    end

    // saturate the signed rate
    assign w_quot_x = {1'b0, w_quot};
    always_comb begin
        if (r_delta[LIM_W-1]) begin
            if (w_quot_x > RATE_NEG_MAG) w_rate = RATE_NEG_MIN;
            else                         w_rate = RATE_W'(-w_quot_x);
        end else begin
            if (w_quot[QUOT_W-1])        w_rate = RATE_POS_MAX;
            else                         w_rate = w_quot;
        end
    end

    // interval gating only once a nonzero time was stored
    assign w_gap      = $signed({1'b0, r_in_t}) - $signed({1'b0, r_last_time});
    assign w_do_store = (r_last_time == '0) || !(w_gap < $signed({1'b0, r_min_int}));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ring_we  = (r_state == S_STORE) && w_out_free && w_do_store;
    assign w_div_start = (r_state == S_DIV_GO);

    always_comb begin
        n_state        = r_state;
        n_win_long     = r_win_long;
        n_lim_cnt      = r_lim_cnt;
        n_next_slot    = r_next_slot;
        n_fill         = r_fill;
        n_last_time    = r_last_time;
        n_out_valid    = r_out_valid;
        n_short_window = r_short_window;
        n_long_window  = r_long_window;
        n_short_scale  = r_short_scale;
        n_fall_fast    = r_fall_fast;
        n_fall         = r_fall;
        n_steady       = r_steady;
        n_rise         = r_rise;
        n_min_int      = r_min_int;
        n_in_p         = r_in_p;
        n_in_t         = r_in_t;
        n_new_p        = r_new_p;
        n_delta        = r_delta;
        n_span         = r_span;
        n_flags        = r_flags;
        n_res_sv       = r_res_sv;
        n_res_sr       = r_res_sr;
        n_res_sc       = r_res_sc;
        n_res_lv       = r_res_lv;
        n_res_lr       = r_res_lr;
        n_res_lc       = r_res_lc;
        n_out_sv       = r_out_sv;
        n_out_sr       = r_out_sr;
        n_out_sc       = r_out_sc;
        n_out_lv       = r_out_lv;
        n_out_lr       = r_out_lr;
        n_out_lc       = r_out_lc;
        n_out_st       = r_out_st;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHORT_WINDOW: n_short_window = i_cfg_wdata[WIN_W-1:0];
                CFG_LONG_WINDOW:  n_long_window  = i_cfg_wdata[WIN_W-1:0];
                CFG_SHORT_SCALE:  n_short_scale  = i_cfg_wdata[SCALE_W-1:0];
                CFG_FALL_FAST:    n_fall_fast    = $signed(i_cfg_wdata[LIM_W-1:0]);
                CFG_FALL:         n_fall         = $signed(i_cfg_wdata[LIM_W-1:0]);
                CFG_STEADY:       n_steady       = i_cfg_wdata[ULIM_W-1:0];
                CFG_RISE:         n_rise         = i_cfg_wdata[ULIM_W-1:0];
                CFG_MIN_INTERVAL: n_min_int      = i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in_p     = i_pressure_pa;
                    n_in_t     = i_sample_time_us;
                    n_win_long = 1'b0;
                    n_state    = S_ADDR;
                end
            end
            S_ADDR: begin
                if (w_win_ok) begin
                    n_state = S_READ;
                end else begin
                    // window out of reach: invalid trend
                    if (r_win_long) begin
                        n_res_lv = 1'b0;
                        n_res_lr = '0;
                        n_res_lc = CLS_STEADY;
                        n_state  = S_STORE;
                    end else begin
                        n_res_sv   = 1'b0;
                        n_res_sr   = '0;
                        n_res_sc   = CLS_STEADY;
                        n_win_long = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_delta = $signed({1'b0, r_new_p}) - $signed({1'b0, r_ring_q[MW-1:TIME_W]});
                n_span  = $signed({1'b0, r_last_time}) - $signed({1'b0, r_ring_q[TIME_W-1:0]});
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_span < MIN_SPAN_US) begin
                    if (r_win_long) begin
                        n_res_lv = 1'b0;
                        n_res_lr = '0;
                        n_res_lc = CLS_STEADY;
                        n_state  = S_STORE;
                    end else begin
                        n_res_sv   = 1'b0;
                        n_res_sr   = '0;
                        n_res_sc   = CLS_STEADY;
                        n_win_long = 1'b1;
                        n_state    = S_ADDR;
                    end
                end else begin
                    n_lim_cnt = '0;
                    n_state   = S_LIM;
                end
            end
            S_LIM: begin
                // product of limit k lands in the next cycle and is compared then
                if (r_lim_cnt != '0) begin
                    n_flags[w_lim_idx] = w_lim_hit;
                end
                if (r_lim_cnt == 3'd4) begin
                    n_state = S_MUL;
                end else begin
                    n_lim_cnt = r_lim_cnt + 3'd1;
                end
            end
            S_MUL: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_win_long) begin
                    n_res_lv = 1'b1;
                    n_res_lr = w_rate;
                    n_res_lc = w_class;
                    n_state  = S_STORE;
                end else begin
                    n_res_sv   = 1'b1;
                    n_res_sr   = w_rate;
                    n_res_sc   = w_class;
                    n_win_long = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_STORE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sv    = r_res_sv;
                    n_out_sr    = r_res_sr;
                    n_out_sc    = r_res_sc;
                    n_out_lv    = r_res_lv;
                    n_out_lr    = r_res_lr;
                    n_out_lc    = r_res_lc;
                    n_out_st    = w_do_store;
                    if (w_do_store) begin
                        n_new_p     = r_in_p;
                        n_last_time = r_in_t;
                        n_next_slot = (r_next_slot == IW'(HISTORY_DEPTH - 1)) ?
                                      '0 : r_next_slot + 1'b1;
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_win_long     <= 1'b0;
            r_lim_cnt      <= '0;
            r_next_slot    <= '0;
            r_fill         <= '0;
            r_last_time    <= '0;
            r_out_valid    <= 1'b0;
            r_short_window <= RST_SHORT_WINDOW;
            r_long_window  <= RST_LONG_WINDOW;
            r_short_scale  <= RST_SHORT_SCALE;
            r_fall_fast    <= RST_FALL_FAST;
            r_fall         <= RST_FALL;
            r_steady       <= RST_STEADY;
            r_rise         <= RST_RISE;
            r_min_int      <= RST_MIN_INTERVAL;
        end else begin
            r_state        <= n_state;
            r_win_long     <= n_win_long;
            r_lim_cnt      <= n_lim_cnt;
            r_next_slot    <= n_next_slot;
            r_fill         <= n_fill;
            r_last_time    <= n_last_time;
            r_out_valid    <= n_out_valid;
            r_short_window <= n_short_window;
            r_long_window  <= n_long_window;
            r_short_scale  <= n_short_scale;
            r_fall_fast    <= n_fall_fast;
            r_fall         <= n_fall;
            r_steady       <= n_steady;
            r_rise         <= n_rise;
            r_min_int      <= n_min_int;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_p   <= n_in_p;
        r_in_t   <= n_in_t;
        r_new_p  <= n_new_p;
        r_delta  <= n_delta;
        r_span   <= n_span;
        r_flags  <= n_flags;
        r_prod   <= w_mul_a * $signed({1'b0, w_mul_b});
        r_res_sv <= n_res_sv;
        r_res_sr <= n_res_sr;
        r_res_sc <= n_res_sc;
        r_res_lv <= n_res_lv;
        r_res_lr <= n_res_lr;
        r_res_lc <= n_res_lc;
        r_out_sv <= n_out_sv;
        r_out_sr <= n_out_sr;
        r_out_sc <= n_out_sc;
        r_out_lv <= n_out_lv;
        r_out_lr <= n_out_lr;
        r_out_lc <= n_out_lc;
        r_out_st <= n_out_st;
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_next_slot] <= {r_in_p, r_in_t};
        end
        r_ring_q <= r_ring[w_rd_addr];
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_short_valid   = r_out_sv;
    assign o_short_rate    = r_out_sr;
    assign o_short_class   = r_out_sc;
    assign o_long_valid    = r_out_lv;
    assign o_long_rate     = r_out_lr;
    assign o_long_class    = r_out_lc;
    assign o_sample_stored = r_out_st;

endmodule

### rtl/ptt_checker.sv
// port-level checks for the pressure trend tracker, bound to the top level
module ptt_checker
    import ptt_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_short_valid,
    input logic signed [RATE_W-1:0] o_short_rate,
    input logic [CLS_W-1:0]         o_short_class,
    input logic                     o_long_valid,
    input logic signed [RATE_W-1:0] o_long_rate,
    input logic [CLS_W-1:0]         o_long_class
);

    // a result stays offered until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted transaction keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transaction");

    // an unavailable trend reads as zero rate, steady class
    a_invalid_trend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_short_valid || (o_short_rate == '0 && o_short_class == CLS_STEADY)) &&
            (o_long_valid || (o_long_rate == '0 && o_long_class == CLS_STEADY)))
        else $error("invalid trend carries a value");

    // class codes stay within the five classes
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_short_class <= CLS_RISE_FAST && o_long_class <= CLS_RISE_FAST)
        else $error("class code out of range");

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind pressure_trend_tracker ptt_checker u_ptt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_short_valid (o_short_valid),
    .o_short_rate  (o_short_rate),
    .o_short_class (o_short_class),
    .o_long_valid  (o_long_valid),
    .o_long_rate   (o_long_rate),
    .o_long_class  (o_long_class)
);

### dv/tb_pressure_trend_tracker.sv
// testbench for the pressure trend tracker: directed and random sample streams
`timescale 1ns / 1ps

module tb_pressure_trend_tracker;
    import ptt_pkg::*;

    localparam int RING_DEPTH  = 96;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 119;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [WIN_W-1:0]        short_win;
        logic [WIN_W-1:0]        long_win;
        logic [SCALE_W-1:0]      short_scale;
        logic signed [LIM_W-1:0] fall_fast;
        logic signed [LIM_W-1:0] fall;
        logic [ULIM_W-1:0]       steady;
        logic [ULIM_W-1:0]       rise;
        logic [TIME_W-1:0]       min_gap;
    } t_settings;

    typedef struct {
        logic                     ok;
        logic signed [RATE_W-1:0] rate;
        logic [CLS_W-1:0]         cls;
    } t_trend;

    typedef struct {
        t_trend short_tr;
        t_trend long_tr;
        logic   stored;
    } t_trend_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [PRES_W-1:0] i_pressure_pa = '0;
    logic [TIME_W-1:0] i_sample_time_us = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_short_valid;
    logic signed [RATE_W-1:0] o_short_rate;
    logic [CLS_W-1:0] o_short_class;
    logic o_long_valid;
    logic signed [RATE_W-1:0] o_long_rate;
    logic [CLS_W-1:0] o_long_class;
    logic o_sample_stored;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predictor state
    logic [PRES_W-1:0] ring_p [RING_DEPTH];
    logic [TIME_W-1:0] ring_t [RING_DEPTH];
    int                wr_slot = 0;
    int                filled = 0;
    logic [TIME_W-1:0] last_kept_us = '0;
    t_settings         cfg;

    t_trend_report trend_reports_due[$];
    t_trend_report due;
    int     mismatches = 0;
    int     cycle_cnt = 0;
    int     send_gap_pct = 0;
    int     out_stall_pct = 0;
    int     stall_left = 0;
    longint clock_us = 0;

    pressure_trend_tracker #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pressure_pa   (i_pressure_pa),
        .i_sample_time_us(i_sample_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_short_valid   (o_short_valid),
        .o_short_rate    (o_short_rate),
        .o_short_class   (o_short_class),
        .o_long_valid    (o_long_valid),
        .o_long_rate     (o_long_rate),
        .o_long_class    (o_long_class),
        .o_sample_stored (o_sample_stored),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // newest stored entry against the one win slots older
    function automatic t_trend window_trend(logic [WIN_W-1:0] win, longint scale);
        t_trend r;
        int     newest;
        int     oldest;
        longint delta;
        longint span;
        longint mag;
        longint quot;
        longint ds;
        r.ok = 1'b0;
        r.rate = '0;
        r.cls = CLS_STEADY;
        if (win >= RING_DEPTH || filled <= win)
            return r;
        newest = (wr_slot + RING_DEPTH - 1) % RING_DEPTH;
        oldest = (newest + RING_DEPTH - int'(win)) % RING_DEPTH;
        delta = longint'(ring_p[newest]) - longint'(ring_p[oldest]);
        span = longint'(ring_t[newest]) - longint'(ring_t[oldest]);
        if (span < longint'(MIN_SPAN_US))
            return r;
        mag = (delta < 0) ? -delta : delta;
        quot = mag * longint'(US_PER_HOUR) / span;
        if (delta < 0)
            r.rate = (quot > longint'(RATE_NEG_MAG)) ? RATE_NEG_MIN : RATE_W'(-quot);
        else
            r.rate = (quot > longint'(RATE_POS_MAX)) ? RATE_POS_MAX : RATE_W'(quot);
        ds = delta * longint'(SCALE_ONE);
        if (ds < longint'(cfg.fall_fast) * scale)
            r.cls = CLS_FALL_FAST;
        else if (ds < longint'(cfg.fall) * scale)
            r.cls = CLS_FALL;
        else if (ds <= longint'(cfg.steady) * scale)
            r.cls = CLS_STEADY;
        else if (ds <= longint'(cfg.rise) * scale)
            r.cls = CLS_RISE;
        else
            r.cls = CLS_RISE_FAST;
        r.ok = 1'b1;
        return r;
    endfunction

    // trends come from the history before this sample, then the sample may be kept
    function automatic t_trend_report compute_trends(logic [PRES_W-1:0] p,
                                                     logic [TIME_W-1:0] t);
        t_trend_report rep;
        longint        since;
        rep.short_tr = window_trend(cfg.short_win, longint'(cfg.short_scale));
        rep.long_tr = window_trend(cfg.long_win, longint'(SCALE_ONE));
        rep.stored = 1'b1;
        if (last_kept_us != '0) begin
            since = longint'(t) - longint'(last_kept_us);
            if (since < longint'(cfg.min_gap))
                rep.stored = 1'b0;
        end
        if (rep.stored) begin
            ring_p[wr_slot] = p;
            ring_t[wr_slot] = t;
            wr_slot = (wr_slot + 1) % RING_DEPTH;
            if (filled < RING_DEPTH)
                filled++;
            last_kept_us = t;
        end
        return rep;
    endfunction

    task automatic check_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (trend_reports_due.size() == 0) begin
                $error("result arrived with no transaction outstanding");
                mismatches++;
            end else begin
                due = trend_reports_due.pop_front();
                check_field("short_valid", due.short_tr.ok, o_short_valid);
                check_field("short_rate", due.short_tr.rate, o_short_rate);
                check_field("short_class", due.short_tr.cls, o_short_class);
                check_field("long_valid", due.long_tr.ok, o_long_valid);
                check_field("long_rate", due.long_tr.rate, o_long_rate);
                check_field("long_class", due.long_tr.cls, o_long_class);
                check_field("sample_stored", due.stored, o_sample_stored);
            end
        end
    end

    // receiver back-pressure: mostly short bursts, now and then a long one
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < out_stall_pct) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(99) >= send_gap_pct)
            return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
    endfunction

    // entered and left at a falling edge; valid stays high if the next one follows
    task automatic push_sample(logic [PRES_W-1:0] p, logic [TIME_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pressure_pa <= p;
        i_sample_time_us <= t;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        trend_reports_due.push_back(compute_trends(p, t));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (trend_reports_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    task automatic load_settings(t_settings s);
        drain();
        repeat (4) @(negedge i_clk);
        write_reg(CFG_SHORT_WINDOW, CFG_DATA_W'(s.short_win));
        write_reg(CFG_LONG_WINDOW, CFG_DATA_W'(s.long_win));
        write_reg(CFG_SHORT_SCALE, CFG_DATA_W'(s.short_scale));
        write_reg(CFG_FALL_FAST, CFG_DATA_W'(s.fall_fast));
        write_reg(CFG_FALL, CFG_DATA_W'(s.fall));
        write_reg(CFG_STEADY, CFG_DATA_W'(s.steady));
        write_reg(CFG_RISE, CFG_DATA_W'(s.rise));
        write_reg(CFG_MIN_INTERVAL, s.min_gap);
        i_cfg_we <= 1'b0;
        cfg = s;
    endtask

    function automatic t_settings pick_settings(int phase);
        t_settings s;
        int        mag;
        int        lvl;
        s.short_win = WIN_W'($urandom_range(12, 1));
        s.long_win = WIN_W'($urandom_range(95, 4));
        case ($urandom_range(9))
            0: s.short_win = '0;
            1: s.long_win = 7'd95;
            2: s.long_win = WIN_W'($urandom_range(127, 96));
            3: s.short_win = 7'd1;
            default: ;
        endcase
        case ($urandom_range(3))
            0: s.short_scale = '0;
            1: s.short_scale = SCALE_W'(SCALE_ONE);
            2: s.short_scale = '1;
            default: s.short_scale = SCALE_W'($urandom_range(65536));
        endcase
        if ($urandom_range(4) == 0) begin
            // arbitrary values, ordering not guaranteed
            s.fall_fast = LIM_W'($urandom);
            s.fall = LIM_W'($urandom);
            s.steady = ULIM_W'($urandom);
            s.rise = ULIM_W'($urandom);
        end else begin
            mag = $urandom_range(3000);
            lvl = $urandom_range(mag);
            s.fall_fast = LIM_W'(-mag);
            s.fall = LIM_W'(-lvl);
            lvl = $urandom_range(1500);
            s.steady = ULIM_W'(lvl);
            s.rise = ULIM_W'(lvl + $urandom_range(1500));
        end
        case ($urandom_range(3))
            0: s.min_gap = '0;
            1: s.min_gap = RST_MIN_INTERVAL;
            default: s.min_gap = TIME_W'($urandom_range(500000000, 100000000));
        endcase
        if (phase == 0) begin
            s.short_win = 7'd1;
            s.long_win = 7'd95;
        end else if (phase == 1) begin
            s.fall_fast = {1'b1, {(LIM_W-1){1'b0}}};
            s.fall = '0;
            s.steady = '0;
            s.rise = '1;
        end else if (phase == 2) begin
            s.short_win = '0;
            s.long_win = 7'd96;
        end else if (phase == 3) begin
            s.short_win = 7'd95;
        end
        return s;
    endfunction

    task automatic test_defaults();
        int walk[11] = '{100000, 99900, 99700, 99950, 100200, 100600,
                         101000, 100990, 100000, 100010, 99000};
        push_sample(17'd30000, '0);         // zero stamp keeps gating off
        push_sample(17'd110000, 48'd1);
        push_sample('1, 48'd900000000);     // one microsecond short of the interval
        push_sample('0, 48'd900000001);     // exactly the interval: kept
        push_sample(17'd65536, 48'd5);      // stamp goes backward
        clock_us = 900000001;
        foreach (walk[k]) begin
            clock_us += longint'(RST_MIN_INTERVAL) + k * 1000;
            push_sample(PRES_W'(walk[k]), TIME_W'(clock_us));
        end
    endtask

    task automatic test_extremes();
        t_settings s;
        s = cfg;
        s.short_win = 7'd1;
        s.long_win = 7'd2;
        s.short_scale = '1;
        s.fall_fast = {1'b1, {(LIM_W-1){1'b0}}};
        s.fall = '0;
        s.steady = '0;
        s.rise = '1;
        s.min_gap = TIME_W'(MIN_SPAN_US);
        load_settings(s);
        // short-window spans of exactly 0.1 h, rate saturates both ways
        clock_us += longint'(MIN_SPAN_US);
        push_sample('0, TIME_W'(clock_us));
        clock_us += longint'(MIN_SPAN_US);
        push_sample('1, TIME_W'(clock_us));
        clock_us += longint'(MIN_SPAN_US);
        push_sample('0, TIME_W'(clock_us));
        clock_us += longint'(MIN_SPAN_US);
        push_sample('0, TIME_W'(clock_us));
        s.min_gap = '0;
        load_settings(s);
        clock_us += longint'(MIN_SPAN_US) - 1;   // span just under 0.1 h
        push_sample(17'd1, TIME_W'(clock_us));
        push_sample(17'd2, TIME_W'(clock_us));    // same stamp, zero span
        s.short_win = '0;
        s.long_win = '1;
        s.min_gap = '1;
        load_settings(s);
        push_sample(17'd101325, TIME_W'(clock_us + 64'd1000000000));
        push_sample(17'd50000, TIME_W'(clock_us + 64'd9000000000));
    endtask

    task automatic test_random_weather();
        t_settings         s;
        int                jump;
        int                spread;
        int                kind;
        int                nxt;
        logic [PRES_W-1:0] p_now;
        logic [TIME_W-1:0] t;
        p_now = 17'd101325;
        for (int phase = 0; phase < PHASES; phase++) begin
            s = pick_settings(phase);
            load_settings(s);
            case ($urandom_range(2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 20;
                default: send_gap_pct = 60;
            endcase
            case ($urandom_range(2))
                0: out_stall_pct = 0;
                1: out_stall_pct = 15;
                default: out_stall_pct = 50;
            endcase
            if (phase == 0) begin
                send_gap_pct = 0;
                out_stall_pct = 0;
            end
            case ($urandom_range(3))
                0: jump = 20;
                1: jump = 300;
                2: jump = 3000;
                default: jump = 40000;
            endcase
            spread = $urandom_range(800000000, 50000000);
            // move into the upper half of the stamp range, and near its top at the end
            if (phase == 6)
                clock_us = 64'h8000_0000_0000 + $urandom;
            if (phase == PHASES - 1)
                clock_us = 64'hFFF8_0000_0000;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && phase % 4 == 1)
                    drain();
                nxt = int'(p_now) + int'($urandom_range(2 * jump)) - jump;
                if (nxt < 0)
                    nxt = 0;
                if (nxt > 131071)
                    nxt = 131071;
                if ($urandom_range(19) == 0)
                    nxt = $urandom_range(131071);
                p_now = PRES_W'(nxt);
                kind = $urandom_range(99);
                if (kind < 85) begin
                    clock_us += longint'(s.min_gap) + $urandom_range(spread);
                    t = TIME_W'(clock_us);
                end else if (kind < 92 && s.min_gap != '0) begin
                    t = TIME_W'(clock_us + longint'($urandom) % longint'(s.min_gap));
                end else if (kind < 96) begin
                    t = TIME_W'(clock_us - 1 - $urandom_range(1000000000));
                end else begin
                    t = TIME_W'(clock_us);
                end
                push_sample(p_now, t);
            end
        end
    endtask

    initial begin
        cfg.short_win = RST_SHORT_WINDOW;
        cfg.long_win = RST_LONG_WINDOW;
        cfg.short_scale = RST_SHORT_SCALE;
        cfg.fall_fast = RST_FALL_FAST;
        cfg.fall = RST_FALL;
        cfg.steady = RST_STEADY;
        cfg.rise = RST_RISE;
        cfg.min_gap = RST_MIN_INTERVAL;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_extremes();
        test_random_weather();
        drain();
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && trend_reports_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
